FILE: sv/lss_pkg.sv
package lss_pkg;

  // Scan, store and sample sizes
  localparam int SCAN_LENGTH = 4096;
  localparam int MAX_RUN     = 128;
  localparam int RANGE_BITS  = 16;

  // Port field widths
  localparam int FIELD_W    = 16;
  localparam int IDX_W      = 12;
  localparam int LEN_W      = 8;
  localparam int MARGIN_W   = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Derived internal widths
  localparam int BEAM_W = $clog2(SCAN_LENGTH);
  localparam int ADDR_W = $clog2(MAX_RUN);
  localparam int CNT_W  = $clog2(MAX_RUN + 2);
  localparam int SUM_W  = RANGE_BITS + $clog2(MAX_RUN);
  localparam int DIVC_W = $clog2(SUM_W + 1);
  localparam int DIFF_W = (RANGE_BITS > FIELD_W) ? RANGE_BITS : FIELD_W;
  localparam int CMP_W  = ((RANGE_BITS > MARGIN_W) ? RANGE_BITS : MARGIN_W) + 1;
  localparam int LCMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // Register reset values
  localparam logic [FIELD_W-1:0]  JUMP_RESET   = 16'd150;
  localparam logic [LEN_W-1:0]    MIN_RESET    = 8'd3;
  localparam logic [LEN_W-1:0]    MAX_RESET    = 8'd100;
  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 10'd5;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JUMP   = 2'd0,
    CFG_MIN    = 2'd1,
    CFG_MAX    = 2'd2,
    CFG_MARGIN = 2'd3
  } cfg_reg_t;

  // Sample store read address select
  typedef enum logic [1:0] {
    RSEL_FIRST = 2'd0,
    RSEL_LAST  = 2'd1,
    RSEL_MID   = 2'd2
  } rd_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    sample_load;
    logic    div_start;
    rd_sel_t rd_sel;
    logic    cap_left;
    logic    cap_right;
    logic    cap_mid;
    logic    out_load;
    logic    end_at_beam;
    logic    out_last;
    logic    update;
    logic    finish;
  } lss_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic emit_old;
    logic emit_new;
    logic div_busy;
  } lss_sts_t;

endpackage

FILE: sv/lss_ram.sv
module lss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/lss_ctrl.sv
module lss_ctrl import lss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     sample_valid,
  output logic     sample_ready,
  output logic     result_valid,
  input  logic     result_ready,
  input  lss_sts_t sts,
  output lss_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_RD_FIRST,
    S_RD_LAST,
    S_RD_MID,
    S_RD_WAIT,
    S_DIV_WAIT,
    S_UPDATE,
    S_FINISH
  } state_t;

  state_t state;
  logic   emit_b;
  logic   phase_b;
  logic   out_ok;

  assign sample_ready = (state == S_IDLE);

  // Load the output register once the mean is ready and the register is free
  assign out_ok = (state == S_DIV_WAIT) && !sts.div_busy && (!result_valid || result_ready);

  // Decode commands
  always_comb begin
    cmd             = '0;
    cmd.sample_load = (state == S_IDLE) && sample_valid;
    cmd.div_start   = (state == S_RD_FIRST);
    case (state)
      S_RD_FIRST: cmd.rd_sel = RSEL_FIRST;
      S_RD_LAST:  cmd.rd_sel = RSEL_LAST;
      S_RD_MID:   cmd.rd_sel = RSEL_MID;
      default:    cmd.rd_sel = RSEL_FIRST;
    endcase
    cmd.cap_left    = (state == S_RD_LAST);
    cmd.cap_right   = (state == S_RD_MID);
    cmd.cap_mid     = (state == S_RD_WAIT);
    cmd.out_load    = out_ok;
    cmd.end_at_beam = phase_b;
    cmd.out_last    = phase_b || !emit_b;
    cmd.update      = (state == S_UPDATE);
    cmd.finish      = (state == S_FINISH);
  end

  // Sequence one sample: close old run, update run, close run at scan end
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      emit_b       <= 1'b0;
      phase_b      <= 1'b0;
    end else begin
      if (out_ok) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          emit_b  <= sts.emit_new;
          phase_b <= 1'b0;
          state   <= sts.emit_old ? S_RD_FIRST : S_UPDATE;
        end
        S_RD_FIRST: state <= S_RD_LAST;
        S_RD_LAST:  state <= S_RD_MID;
        S_RD_MID:   state <= S_RD_WAIT;
        S_RD_WAIT:  state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (out_ok) begin
            state <= phase_b ? S_FINISH : S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (emit_b) begin
            phase_b <= 1'b1;
            state   <= S_RD_FIRST;
          end else begin
            state <= S_FINISH;
          end
        end
        S_FINISH: state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/lss_datapath.sv
module lss_datapath import lss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [FIELD_W-1:0]    range_mm,
  input  logic                  range_valid,
  input  logic                  scan_end,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  lss_cmd_t              cmd,
  output lss_sts_t              sts,
  output logic [IDX_W-1:0]      run_start,
  output logic [IDX_W-1:0]      run_end,
  output logic [FIELD_W-1:0]    mean_range,
  output logic                  is_table,
  output logic                  last_of_run
);

  // Configuration
  logic [FIELD_W-1:0]    jump_threshold;
  logic [LEN_W-1:0]      min_run_length;
  logic [LEN_W-1:0]      max_run_length;
  logic [MARGIN_W-1:0]   convex_margin;

  // Current sample
  logic [RANGE_BITS-1:0] s_range;
  logic                  s_valid;
  logic                  s_end;

  // Run state
  logic [BEAM_W-1:0]     beam_index;
  logic                  run_active;
  logic [BEAM_W-1:0]     run_first;
  logic [CNT_W-1:0]      run_count;
  logic [RANGE_BITS-1:0] prev_range;
  logic [SUM_W-1:0]      range_sum;

  // Sample store access
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [ADDR_W-1:0]     rd_addr;
  logic [RANGE_BITS-1:0] rd_data;
  logic [CNT_W-1:0]      cnt_m1;
  logic [CNT_W-1:0]      mid_wide;

  // End samples of the closing run
  logic [RANGE_BITS-1:0] left;
  logic [RANGE_BITS-1:0] right;
  logic [RANGE_BITS-1:0] mid;

  // Divider
  logic [SUM_W-1:0]      quo;
  logic [SUM_W-1:0]      quo_next;
  logic [CNT_W-1:0]      rem;
  logic [CNT_W-1:0]      rem_next;
  logic [CNT_W-1:0]      divisor;
  logic [DIVC_W-1:0]     div_cnt;
  logic                  div_busy;
  logic [CNT_W:0]        trial;

  // Decision terms
  logic [DIFF_W-1:0]     diff_a;
  logic [DIFF_W-1:0]     diff_b;
  logic [DIFF_W-1:0]     diff;
  logic                  jump;
  logic                  restart;
  logic                  room;
  logic [CNT_W-1:0]      count_next;
  logic [BEAM_W-1:0]     beam_before;
  logic [BEAM_W-1:0]     beam_next;
  logic [CMP_W-1:0]      mid_margin;

  function automatic logic fits(input logic [CNT_W-1:0] c,
                                input logic [LEN_W-1:0] lo,
                                input logic [LEN_W-1:0] hi);
    logic [LCMP_W-1:0] cc;
    cc = LCMP_W'(c);
    return (c != '0) && (cc >= LCMP_W'(lo)) && (cc <= LCMP_W'(hi)) &&
           (cc <= LCMP_W'(MAX_RUN));
  endfunction

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_threshold <= JUMP_RESET;
      min_run_length <= MIN_RESET;
      max_run_length <= MAX_RESET;
      convex_margin  <= MARGIN_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_JUMP:   jump_threshold <= cfg_data;
        CFG_MIN:    min_run_length <= cfg_data[LEN_W-1:0];
        CFG_MAX:    max_run_length <= cfg_data[LEN_W-1:0];
        CFG_MARGIN: convex_margin  <= cfg_data[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted sample
  always_ff @(posedge clk) begin
    if (cmd.sample_load) begin
      s_range <= RANGE_BITS'(range_mm);
      s_valid <= range_valid;
      s_end   <= scan_end;
    end
  end

  // Jump test and next run length
  always_comb begin
    diff_a  = DIFF_W'(s_range);
    diff_b  = DIFF_W'(prev_range);
    diff    = (diff_a > diff_b) ? (diff_a - diff_b) : (diff_b - diff_a);
    jump    = diff > DIFF_W'(jump_threshold);
    restart = !run_active || jump;
    room    = run_count < CNT_W'(MAX_RUN);
    if (restart) begin
      count_next = CNT_W'(1);
    end else if (room) begin
      count_next = run_count + CNT_W'(1);
    end else begin
      count_next = CNT_W'(MAX_RUN + 1);
    end
  end

  assign sts.emit_old = run_active && (!s_valid || jump) &&
                        fits(run_count, min_run_length, max_run_length);
  assign sts.emit_new = s_end && s_valid && fits(count_next, min_run_length, max_run_length);
  assign sts.div_busy = div_busy;

  // Beam index neighbors, wrapping at the scan length
  assign beam_before = (beam_index == '0) ? BEAM_W'(SCAN_LENGTH - 1) :
                       (beam_index - BEAM_W'(1));
  assign beam_next   = (beam_index == BEAM_W'(SCAN_LENGTH - 1)) ? '0 :
                       (beam_index + BEAM_W'(1));

  // Open, extend or close the run; advance the beam index
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_index <= '0;
      run_active <= 1'b0;
      run_first  <= '0;
      run_count  <= '0;
      prev_range <= '0;
      range_sum  <= '0;
    end else begin
      if (cmd.update) begin
        if (s_valid) begin
          prev_range <= s_range;
          run_active <= 1'b1;
          run_count  <= count_next;
          if (restart) begin
            run_first <= beam_index;
            range_sum <= SUM_W'(s_range);
          end else if (room) begin
            range_sum <= range_sum + SUM_W'(s_range);
          end
        end else begin
          run_active <= 1'b0;
        end
      end
      if (cmd.finish) begin
        if (s_end) begin
          run_active <= 1'b0;
          beam_index <= '0;
        end else begin
          beam_index <= beam_next;
        end
      end
    end
  end

  // Sample store addressing
  assign wr_en    = cmd.update && s_valid && (restart || room);
  assign wr_addr  = restart ? '0 : run_count[ADDR_W-1:0];
  assign cnt_m1   = run_count - CNT_W'(1);
  assign mid_wide = cnt_m1 >> 1;

  always_comb begin
    case (cmd.rd_sel)
      RSEL_FIRST: rd_addr = '0;
      RSEL_LAST:  rd_addr = cnt_m1[ADDR_W-1:0];
      RSEL_MID:   rd_addr = mid_wide[ADDR_W-1:0];
      default:    rd_addr = '0;
    endcase
  end

  lss_ram #(
    .WIDTH (RANGE_BITS),
    .DEPTH (MAX_RUN)
  ) u_samples (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (s_range),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Capture first, last and middle samples
  always_ff @(posedge clk) begin
    if (cmd.cap_left) begin
      left <= rd_data;
    end
    if (cmd.cap_right) begin
      right <= rd_data;
    end
    if (cmd.cap_mid) begin
      mid <= rd_data;
    end
  end

  // Restoring divider step: one quotient bit per cycle
  always_comb begin
    trial = {rem, quo[SUM_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_next = CNT_W'(trial - {1'b0, divisor});
      quo_next = {quo[SUM_W-2:0], 1'b1};
    end else begin
      rem_next = trial[CNT_W-1:0];
      quo_next = {quo[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.div_start) begin
      quo      <= range_sum;
      divisor  <= run_count;
      rem      <= '0;
      div_cnt  <= DIVC_W'(SUM_W);
      div_busy <= 1'b1;
    end else if (div_busy) begin
      quo     <= quo_next;
      rem     <= rem_next;
      div_cnt <= div_cnt - DIVC_W'(1);
      if (div_cnt == DIVC_W'(1)) begin
        div_busy <= 1'b0;
      end
    end
  end

  // Output register
  assign mid_margin = CMP_W'(mid) + CMP_W'(convex_margin);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      run_start   <= IDX_W'(run_first);
      run_end     <= IDX_W'(cmd.end_at_beam ? beam_index : beam_before);
      mean_range  <= FIELD_W'(quo);
      is_table    <= (CMP_W'(left) > mid_margin) && (CMP_W'(right) > mid_margin);
      last_of_run <= cmd.out_last;
    end
  end

endmodule

FILE: sv/lidar_scan_segmenter.sv
// A sample that closes no run passes only the idle, decide, update and finish states.
// A sample that closes one run adds 3 store reads that overlap the restoring divider for
// the mean, once per closed run; the result loads once the output register is free.
// Throughput: one sample at a time, set by the divider, the store port and result_ready.
// Reset (rst, synchronous): registers return to defaults, run state and beam index clear.
module lidar_scan_segmenter import lss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  logic [FIELD_W-1:0]    range_mm,
  input  logic                  range_valid,
  input  logic                  scan_end,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic [IDX_W-1:0]      run_start,
  output logic [IDX_W-1:0]      run_end,
  output logic [FIELD_W-1:0]    mean_range,
  output logic                  is_table,
  output logic                  last_of_run,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lss_cmd_t cmd;
  lss_sts_t sts;

  // Sequencer
  lss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Run tracking, sample store, divider and output register
  lss_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .range_mm    (range_mm),
    .range_valid (range_valid),
    .scan_end    (scan_end),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .run_start   (run_start),
    .run_end     (run_end),
    .mean_range  (mean_range),
    .is_table    (is_table),
    .last_of_run (last_of_run)
  );

endmodule
